// File: rtl/core/wmif_pkg.sv
// Shared constants for the window median image filter.
`default_nettype none
package wmif_pkg;
  localparam int unsigned MaxWindow = 7;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned PixelBits = 8;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned PosW      = 10;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindowSize  = 2'd2;
endpackage
`default_nettype wire

// File: rtl/core/window_median_image_filter_core.sv
// Top level of the square-window median filter with bit-serial median selection.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | pixel, start_of_frame
//  out     | output    | out_valid/out_stall| median, centre_row, centre_col, last_of_frame
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pixel that completes a window passes through acceptance with the line store read, window
// shift and store write, search load, one bit plane of the median search per cycle, and one
// result write. A border pixel passes acceptance and the shift and write, with no request.
// The line store is one memory with one read and one write port.
// Reset clears control state and loads the register defaults; no store clearing pass.
// A finished result waits in the output register while the next item runs; a stalled result
// holds the core in its result write cycle.
`default_nettype none
module window_median_image_filter_core
  import wmif_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MaxWindow,
  parameter int unsigned MAX_WIDTH  = MaxWidth,
  parameter int unsigned PIXEL_BITS = PixelBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel_i,
  input  wire logic                  start_of_frame_i,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 median_o,
  output logic [PosW-1:0]            centre_row_o,
  output logic [PosW-1:0]            centre_col_o,
  output logic                       last_of_frame_o,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data
);
  localparam int unsigned NL   = MAX_WINDOW - 1;
  localparam int unsigned LW   = PIXEL_BITS * NL;
  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned WSW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NE   = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned NEW  = $clog2(NE + 1);
  localparam int unsigned BW   = $clog2(PIXEL_BITS + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StBits = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [CfgDataW-1:0] width_q, height_q;
  logic [2:0]          wsize_q;
  logic [2:0]          state_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [CW-1:0]       col_q, row_q, c_q, r_q;
  logic [CW-1:0]       wd, ht;
  logic [WSW-1:0]      w;
  logic [LW-1:0]       line_mem [MAX_WIDTH];
  logic [LW-1:0]       rd_q;
  logic [PIXEL_BITS-1:0] win_q [MAX_WINDOW][MAX_WINDOW];
  logic [PIXEL_BITS-1:0] shr_q [NE];
  logic [NE-1:0]       act_q;
  logic [NEW-1:0]      rank_q;
  logic [BW-1:0]       bit_q;
  logic [PIXEL_BITS-1:0] med_q;
  logic                emit_q, lastf_q;
  logic                ov_q;
  logic [7:0]          med_o_q;
  logic [PosW-1:0]     crow_q, ccol_q;
  logic                lof_q;

  always_comb begin
    if (width_q < CfgDataW'(2)) wd = CW'(2);
    else if (32'(width_q) > MAX_WIDTH) wd = CW'(MAX_WIDTH);
    else wd = CW'(width_q);
    if (height_q < CfgDataW'(2)) ht = CW'(2);
    else if (height_q > CfgDataW'(MaxHeight)) ht = CW'(MaxHeight);
    else ht = CW'(height_q);
    if (wsize_q < 3'd2) w = WSW'(2);
    else if ({{(32-3){1'b0}}, wsize_q} > MAX_WINDOW) w = WSW'(MAX_WINDOW);
    else w = WSW'(wsize_q);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDataW'(640);
      height_q <= CfgDataW'(480);
      wsize_q  <= 3'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegImageWidth:  width_q  <= cfg_data;
        RegImageHeight: height_q <= cfg_data;
        RegWindowSize:  wsize_q  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // bit-plane count of zeros among active elements
  logic [NEW-1:0] zeros;
  logic [NE-1:0]  is_zero;
  always_comb begin
    for (int i = 0; i < NE; i++) is_zero[i] = act_q[i] & ~shr_q[i][PIXEL_BITS-1];
    zeros = '0;
    for (int i = 0; i < NE; i++) zeros = zeros + NEW'(is_zero[i]);
  end

  logic [CW-1:0] cpos, rpos;
  always_comb begin
    cpos = start_of_frame_i ? '0 : col_q;
    rpos = start_of_frame_i ? '0 : row_q;
    if (cpos >= wd) cpos = '0;
    if (rpos >= ht) rpos = '0;
  end

  logic win_ok;
  assign win_ok = (r_q + CW'(1) >= CW'(w)) && (c_q + CW'(1) >= CW'(w));

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid) rd_q <= line_mem[cpos[AW-1:0]];
    if (state_q == StRead) begin
      line_mem[c_q[AW-1:0]] <= LW'({rd_q, pix_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid) pix_q <= pixel_i;
    if (state_q == StRead) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        for (int j = 0; j + 1 < MAX_WINDOW; j++) win_q[k][j] <= win_q[k][j+1];
      end
      win_q[0][MAX_WINDOW-1] <= pix_q;
      for (int k = 1; k < MAX_WINDOW; k++)
        win_q[k][MAX_WINDOW-1] <= rd_q[PIXEL_BITS*(k-1) +: PIXEL_BITS];
    end
    if (state_q == StLoad) begin
      for (int k = 0; k < MAX_WINDOW; k++)
        for (int j = 0; j < MAX_WINDOW; j++) shr_q[k*MAX_WINDOW+j] <= win_q[k][j];
    end
    if (state_q == StBits) begin
      for (int i = 0; i < NE; i++) shr_q[i] <= shr_q[i] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q <= '0; row_q <= '0; c_q <= '0; r_q <= '0;
      act_q <= '0; rank_q <= '0; bit_q <= '0; med_q <= '0;
      emit_q <= 1'b0; lastf_q <= 1'b0;
      ov_q <= 1'b0; med_o_q <= '0; crow_q <= '0; ccol_q <= '0; lof_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall && state_q != StDone) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid) begin
            c_q <= cpos; r_q <= rpos;
            if (cpos + CW'(1) >= wd) begin
              col_q <= '0;
              row_q <= (rpos + CW'(1) >= ht) ? '0 : rpos + CW'(1);
            end else begin
              col_q <= cpos + CW'(1);
              row_q <= rpos;
            end
            state_q <= StRead;
          end
        end
        StRead: begin
          emit_q  <= win_ok;
          lastf_q <= (r_q + CW'(1) == ht) && (c_q + CW'(1) == wd);
          state_q <= win_ok ? StLoad : StIdle;
        end
        StLoad: begin
          for (int k = 0; k < MAX_WINDOW; k++)
            for (int j = 0; j < MAX_WINDOW; j++)
              act_q[k*MAX_WINDOW+j] <= (k < int'(w)) && (j >= MAX_WINDOW - int'(w));
          rank_q  <= NEW'((int'(w) * int'(w) - 1) / 2);
          bit_q   <= '0;
          state_q <= StBits;
        end
        StBits: begin
          med_q <= {med_q[PIXEL_BITS-2:0], (rank_q >= zeros)};
          if (rank_q >= zeros) begin
            rank_q <= rank_q - zeros;
            act_q  <= act_q & ~is_zero;
          end else begin
            act_q  <= is_zero;
          end
          bit_q <= bit_q + BW'(1);
          if (bit_q == BW'(PIXEL_BITS - 1)) state_q <= StDone;
        end
        StDone: begin
          if (!ov_q || !out_stall) begin
            ov_q    <= 1'b1;
            med_o_q <= med_q[7:0];
            crow_q  <= PosW'(r_q + CW'(1) - CW'(w) + CW'((int'(w) - 1) / 2));
            ccol_q  <= PosW'(c_q + CW'(1) - CW'(w) + CW'((int'(w) - 1) / 2));
            lof_q   <= lastf_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid       = ov_q;
  assign median_o        = med_o_q;
  assign centre_row_o    = crow_q;
  assign centre_col_o    = ccol_q;
  assign last_of_frame_o = lof_q;

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(median_o)))
    else $error("result dropped");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (c_q < wd)) else $error("column out of range");
  a_emit_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> emit_q) else $error("median without window");
`endif
endmodule
`default_nettype wire
